FILE: hw/rtl/lenp_pkg.sv
// Shared types, constants and fixed-point helpers for the lens distortion projector.
// No dependencies.
`timescale 1ns / 1ps
package lenp_pkg;

   localparam int DW = 32;              // word width
   localparam int FB = 24;              // fraction bits of Q8.24
   localparam int IB = DW - FB;         // integer bits
   localparam int DIV_STEP = 4;         // quotient bits per divider stage
   localparam int DIV_ST = DW / DIV_STEP;
   localparam int DIV_NST = DIV_ST + 2; // setup + iterate + finish
   localparam int POLY_NST = 9;
   localparam int NST = DIV_NST + POLY_NST;
   localparam int CSR_IW = 3;

   localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] QONE = DW'(1) << FB;
   localparam logic [2*DW-1:0] HALF = (2*DW)'(1) << (FB - 1);

   localparam logic [CSR_IW-1:0] REG_TAN_ONE = 3'd0;
   localparam logic [CSR_IW-1:0] REG_TAN_TWO = 3'd1;
   localparam logic [CSR_IW-1:0] REG_RAD_ONE = 3'd2;
   localparam logic [CSR_IW-1:0] REG_RAD_TWO = 3'd3;
   localparam logic [CSR_IW-1:0] REG_RAD_THREE = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DEPTH = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic signed [DW-1:0] point_x;
      logic signed [DW-1:0] point_y;
      logic signed [DW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] dist_x;
      logic signed [DW-1:0] dist_y;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic signed [DW-1:0] tangential_one;
      logic signed [DW-1:0] tangential_two;
      logic signed [DW-1:0] radial_one;
      logic signed [DW-1:0] radial_two;
      logic signed [DW-1:0] radial_three;
   } coef_type;

   typedef struct packed {
      logic signed [DW-1:0] val;
      logic                 sat;
   } res_type;

   typedef struct packed {
      logic signed [DW-1:0] val;
      logic                 sat;
      logic                 bad;
   } div_out_type;

   // Q8.24 product, round half away from zero, clamped
   function automatic res_type mul_q(input logic signed [DW-1:0] a,
                                     input logic signed [DW-1:0] b);
      logic            neg;
      logic [DW-1:0]   ua;
      logic [DW-1:0]   ub;
      logic [2*DW-1:0] p;
      logic [2*DW-1:0] rl;
      logic [DW-1:0]   lim;
      res_type         r;
      neg = a[DW-1] ^ b[DW-1];
      ua = a[DW-1] ? (~a + 1'b1) : a;
      ub = b[DW-1] ? (~b + 1'b1) : b;
      p = (2*DW)'(ua) * (2*DW)'(ub);
      rl = (p + HALF) >> FB;
      lim = neg ? SMIN : SMAX;
      r.sat = rl > (2*DW)'(lim);
      if (r.sat) begin
         r.val = neg ? SMIN : SMAX;
      end else begin
         r.val = neg ? (~rl[DW-1:0] + 1'b1) : rl[DW-1:0];
      end
      return r;
   endfunction

   // saturating sum
   function automatic res_type add_q(input logic signed [DW-1:0] a,
                                     input logic signed [DW-1:0] b);
      logic [DW:0] s;
      res_type     r;
      s = {a[DW-1], a} + {b[DW-1], b};
      r.sat = s[DW] != s[DW-1];
      if (r.sat) begin
         r.val = s[DW] ? SMIN : SMAX;
      end else begin
         r.val = s[DW-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/lens_distortion_projector.sv
// Lens distortion projector (Brown-Conrady): top level with handshakes and registers.
// Depends on lenp_pkg, lenp_div, lenp_distort.
//
// Usage:
//   req channel: one beat per 3-D point (Q16.16 x, y, z) on req_data.
//   rsp channel: one beat per point, distorted normalized x, y (Q8.24) and status
//     (ok, depth not positive with zero outputs, or saturated).
//   csr channel: always ready; csr_index selects p1, p2, k1, k2, k3 (Q8.24),
//     other indexes are dropped. Write only while no point is in flight.
// Datapath: a 10-stage divider (4 quotient bits per stage) and a 9-stage
// polynomial pipeline with at most one multiply per path per stage. Throughput is
// one point per cycle while rsp_ready does not stall the pipeline.
// Every stage has its own valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles collapse and req_ready stays high while the
// pipeline has a free slot even if rsp_ready is low. A stalled rsp beat holds.
// Reset (synchronous) empties the pipeline and clears all coefficients.
`timescale 1ns / 1ps
module lens_distortion_projector import lenp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [DW-1:0]     csr_data
);

   coef_type       coef_ff;
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] en;
   div_out_type    xq, yq;

   // coefficient registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TAN_ONE:   coef_ff.tangential_one <= csr_data;
            REG_TAN_TWO:   coef_ff.tangential_two <= csr_data;
            REG_RAD_ONE:   coef_ff.radial_one <= csr_data;
            REG_RAD_TWO:   coef_ff.radial_two <= csr_data;
            REG_RAD_THREE: coef_ff.radial_three <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when empty or when its successor moves
   always_comb begin
      en[NST-1] = !valid_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NST-1];

   // x / z and y / z
   lenp_div u_div_x (
      .clock (clock),
      .en    (en[DIV_NST-1:0]),
      .num   (req_data.point_x),
      .den   (req_data.point_z),
      .res   (xq)
   );

   lenp_div u_div_y (
      .clock (clock),
      .en    (en[DIV_NST-1:0]),
      .num   (req_data.point_y),
      .den   (req_data.point_z),
      .res   (yq)
   );

   // radial and tangential distortion
   lenp_distort u_distort (
      .clock (clock),
      .en    (en[NST-1:DIV_NST]),
      .coef  (coef_ff),
      .xin   (xq),
      .yin   (yq),
      .rsp   (rsp_data)
   );

endmodule

FILE: hw/rtl/lenp_div.sv
// Pipelined restoring divider: signed numerator over positive depth, Q8.24 quotient.
// Depends on lenp_pkg.
`timescale 1ns / 1ps
module lenp_div import lenp_pkg::*; (
   input  logic                 clock,
   input  logic [DIV_NST-1:0]   en,
   input  logic signed [DW-1:0] num,
   input  logic signed [DW-1:0] den,
   output div_out_type          res
);

   logic [DW-1:0] rem_ff [DIV_ST+1];
   logic [DW-1:0] nb_ff  [DIV_ST+1];
   logic [DW-1:0] q_ff   [DIV_ST+1];
   logic [DW-1:0] ud_ff  [DIV_ST+1];
   logic          neg_ff [DIV_ST+1];
   logic          ovf_ff [DIV_ST+1];
   logic          bad_ff [DIV_ST+1];
   div_out_type   res_ff;

   logic [DW-1:0] un;
   logic [DW-1:0] ud;
   logic          bad;

   always_comb begin
      un = num[DW-1] ? (~num + 1'b1) : num;
      bad = den[DW-1] || (den == '0);
      ud = bad ? DW'(1) : den;
   end

   // dividend is un << FB; its top DW-IB bits seed the remainder
   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= un >> IB;
         nb_ff[0]  <= {un[IB-1:0], {FB{1'b0}}};
         q_ff[0]   <= '0;
         ud_ff[0]  <= ud;
         neg_ff[0] <= num[DW-1];
         ovf_ff[0] <= (un >> IB) >= ud;
         bad_ff[0] <= bad;
      end
   end

   for (genvar i = 0; i < DIV_ST; i++) begin : g_iter
      logic [DW-1:0] r_c;
      logic [DW-1:0] n_c;
      logic [DW-1:0] q_c;

      always_comb begin
         r_c = rem_ff[i];
         n_c = nb_ff[i];
         q_c = q_ff[i];
         for (int j = 0; j < DIV_STEP; j++) begin
            r_c = {r_c[DW-2:0], n_c[DW-1]};
            n_c = n_c << 1;
            if (r_c >= ud_ff[i]) begin
               r_c = r_c - ud_ff[i];
               q_c = {q_c[DW-2:0], 1'b1};
            end else begin
               q_c = {q_c[DW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[i+1]) begin
            rem_ff[i+1] <= r_c;
            nb_ff[i+1]  <= n_c;
            q_ff[i+1]   <= q_c;
            ud_ff[i+1]  <= ud_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            bad_ff[i+1] <= bad_ff[i];
         end
      end
   end

   // sign and clamp
   div_out_type res_in;
   logic [DW-1:0] lim;

   always_comb begin
      lim = neg_ff[DIV_ST] ? SMIN : SMAX;
      res_in.bad = bad_ff[DIV_ST];
      res_in.sat = ovf_ff[DIV_ST] || (q_ff[DIV_ST] > lim);
      if (res_in.sat) begin
         res_in.val = neg_ff[DIV_ST] ? SMIN : SMAX;
      end else begin
         res_in.val = neg_ff[DIV_ST] ? (~q_ff[DIV_ST] + 1'b1) : q_ff[DIV_ST];
      end
   end

   always_ff @(posedge clock) begin
      if (en[DIV_NST-1]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

FILE: hw/rtl/lenp_distort.sv
// Distortion polynomial pipeline: r^2..r^6, radial scale, tangential terms, final sum.
// Depends on lenp_pkg.
`timescale 1ns / 1ps
module lenp_distort import lenp_pkg::*; (
   input  logic                clock,
   input  logic [POLY_NST-1:0] en,
   input  coef_type            coef,
   input  div_out_type         xin,
   input  div_out_type         yin,
   output rsp_type             rsp
);

   logic          sat_ff [POLY_NST-1];
   logic          bad_ff [POLY_NST-1];
   logic [DW-1:0] x_ff   [POLY_NST-2];
   logic [DW-1:0] y_ff   [POLY_NST-2];

   // stage 0: xy, xx, yy
   res_type m_xy, m_xx, m_yy;
   logic [DW-1:0] xy0_ff, xx0_ff, yy0_ff;
   always_comb begin
      m_xy = mul_q(xin.val, yin.val);
      m_xx = mul_q(xin.val, xin.val);
      m_yy = mul_q(yin.val, yin.val);
   end
   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0] <= xin.val;
         y_ff[0] <= yin.val;
         xy0_ff <= m_xy.val;
         xx0_ff <= m_xx.val;
         yy0_ff <= m_yy.val;
         sat_ff[0] <= xin.sat | yin.sat | m_xy.sat | m_xx.sat | m_yy.sat;
         bad_ff[0] <= xin.bad;
      end
   end

   // stage 1: r2, 2xx, 2yy
   res_type a_r2, a_xx2, a_yy2;
   logic [DW-1:0] xy1_ff, r2_1_ff, xx2_1_ff, yy2_1_ff;
   always_comb begin
      a_r2 = add_q(xx0_ff, yy0_ff);
      a_xx2 = add_q(xx0_ff, xx0_ff);
      a_yy2 = add_q(yy0_ff, yy0_ff);
   end
   always_ff @(posedge clock) begin
      if (en[1]) begin
         x_ff[1] <= x_ff[0];
         y_ff[1] <= y_ff[0];
         xy1_ff <= xy0_ff;
         r2_1_ff <= a_r2.val;
         xx2_1_ff <= a_xx2.val;
         yy2_1_ff <= a_yy2.val;
         sat_ff[1] <= sat_ff[0] | a_r2.sat | a_xx2.sat | a_yy2.sat;
         bad_ff[1] <= bad_ff[0];
      end
   end

   // stage 2: r4, k1*r2, p1*xy, p2*xy, r2+2xx, r2+2yy
   res_type m_r4, m_k1, m_pxy, m_qxy, a_ta, a_tb;
   logic [DW-1:0] r2_2_ff, r4_2_ff, k1_2_ff, pxy2_ff, qxy2_ff, ta2_ff, tb2_ff;
   always_comb begin
      m_r4 = mul_q(r2_1_ff, r2_1_ff);
      m_k1 = mul_q(coef.radial_one, r2_1_ff);
      m_pxy = mul_q(coef.tangential_one, xy1_ff);
      m_qxy = mul_q(coef.tangential_two, xy1_ff);
      a_ta = add_q(r2_1_ff, xx2_1_ff);
      a_tb = add_q(r2_1_ff, yy2_1_ff);
   end
   always_ff @(posedge clock) begin
      if (en[2]) begin
         x_ff[2] <= x_ff[1];
         y_ff[2] <= y_ff[1];
         r2_2_ff <= r2_1_ff;
         r4_2_ff <= m_r4.val;
         k1_2_ff <= m_k1.val;
         pxy2_ff <= m_pxy.val;
         qxy2_ff <= m_qxy.val;
         ta2_ff <= a_ta.val;
         tb2_ff <= a_tb.val;
         sat_ff[2] <= sat_ff[1] | m_r4.sat | m_k1.sat | m_pxy.sat | m_qxy.sat
                      | a_ta.sat | a_tb.sat;
         bad_ff[2] <= bad_ff[1];
      end
   end

   // stage 3: r6, k2*r4, tangential products, doubled cross terms
   res_type m_r6, m_k2, m_tx, m_ty, a_xt0, a_yt0;
   logic [DW-1:0] k1_3_ff, r6_3_ff, k2_3_ff, tx3_ff, ty3_ff, xt0_3_ff, yt0_3_ff;
   always_comb begin
      m_r6 = mul_q(r2_2_ff, r4_2_ff);
      m_k2 = mul_q(coef.radial_two, r4_2_ff);
      m_tx = mul_q(coef.tangential_two, ta2_ff);
      m_ty = mul_q(coef.tangential_one, tb2_ff);
      a_xt0 = add_q(pxy2_ff, pxy2_ff);
      a_yt0 = add_q(qxy2_ff, qxy2_ff);
   end
   always_ff @(posedge clock) begin
      if (en[3]) begin
         x_ff[3] <= x_ff[2];
         y_ff[3] <= y_ff[2];
         k1_3_ff <= k1_2_ff;
         r6_3_ff <= m_r6.val;
         k2_3_ff <= m_k2.val;
         tx3_ff <= m_tx.val;
         ty3_ff <= m_ty.val;
         xt0_3_ff <= a_xt0.val;
         yt0_3_ff <= a_yt0.val;
         sat_ff[3] <= sat_ff[2] | m_r6.sat | m_k2.sat | m_tx.sat | m_ty.sat
                      | a_xt0.sat | a_yt0.sat;
         bad_ff[3] <= bad_ff[2];
      end
   end

   // stage 4: k3*r6, k1r2+k2r4, tangential sums
   res_type m_k3, a_rad0, a_xt, a_yt;
   logic [DW-1:0] k3_4_ff, rad0_4_ff, xt4_ff, yt4_ff;
   always_comb begin
      m_k3 = mul_q(coef.radial_three, r6_3_ff);
      a_rad0 = add_q(k1_3_ff, k2_3_ff);
      a_xt = add_q(xt0_3_ff, tx3_ff);
      a_yt = add_q(yt0_3_ff, ty3_ff);
   end
   always_ff @(posedge clock) begin
      if (en[4]) begin
         x_ff[4] <= x_ff[3];
         y_ff[4] <= y_ff[3];
         k3_4_ff <= m_k3.val;
         rad0_4_ff <= a_rad0.val;
         xt4_ff <= a_xt.val;
         yt4_ff <= a_yt.val;
         sat_ff[4] <= sat_ff[3] | m_k3.sat | a_rad0.sat | a_xt.sat | a_yt.sat;
         bad_ff[4] <= bad_ff[3];
      end
   end

   // stage 5: full radial term
   res_type a_rad;
   logic [DW-1:0] rad5_ff, xt5_ff, yt5_ff;
   assign a_rad = add_q(rad0_4_ff, k3_4_ff);
   always_ff @(posedge clock) begin
      if (en[5]) begin
         x_ff[5] <= x_ff[4];
         y_ff[5] <= y_ff[4];
         rad5_ff <= a_rad.val;
         xt5_ff <= xt4_ff;
         yt5_ff <= yt4_ff;
         sat_ff[5] <= sat_ff[4] | a_rad.sat;
         bad_ff[5] <= bad_ff[4];
      end
   end

   // stage 6: scale s = 1 + radial
   res_type a_s;
   logic [DW-1:0] s6_ff, xt6_ff, yt6_ff;
   assign a_s = add_q(QONE, rad5_ff);
   always_ff @(posedge clock) begin
      if (en[6]) begin
         x_ff[6] <= x_ff[5];
         y_ff[6] <= y_ff[5];
         s6_ff <= a_s.val;
         xt6_ff <= xt5_ff;
         yt6_ff <= yt5_ff;
         sat_ff[6] <= sat_ff[5] | a_s.sat;
         bad_ff[6] <= bad_ff[5];
      end
   end

   // stage 7: x*s, y*s
   res_type m_xs, m_ys;
   logic [DW-1:0] xs7_ff, ys7_ff, xt7_ff, yt7_ff;
   always_comb begin
      m_xs = mul_q(x_ff[6], s6_ff);
      m_ys = mul_q(y_ff[6], s6_ff);
   end
   always_ff @(posedge clock) begin
      if (en[7]) begin
         xs7_ff <= m_xs.val;
         ys7_ff <= m_ys.val;
         xt7_ff <= xt6_ff;
         yt7_ff <= yt6_ff;
         sat_ff[7] <= sat_ff[6] | m_xs.sat | m_ys.sat;
         bad_ff[7] <= bad_ff[6];
      end
   end

   // stage 8: final sums, status, output register
   res_type a_xo, a_yo;
   rsp_type rsp_in, rsp_ff;
   always_comb begin
      a_xo = add_q(xs7_ff, xt7_ff);
      a_yo = add_q(ys7_ff, yt7_ff);
      if (bad_ff[7]) begin
         rsp_in.dist_x = '0;
         rsp_in.dist_y = '0;
         rsp_in.status = ST_DEPTH;
      end else begin
         rsp_in.dist_x = a_xo.val;
         rsp_in.dist_y = a_yo.val;
         rsp_in.status = (sat_ff[7] | a_xo.sat | a_yo.sat) ? ST_SAT : ST_OK;
      end
   end
   always_ff @(posedge clock) begin
      if (en[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: hw/rtl/lenp_chk.sv
// Port-level checks for the lens distortion projector, bound to the top level.
// Depends on lenp_pkg and lens_distortion_projector.
`timescale 1ns / 1ps
module lenp_chk import lenp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_DEPTH
                     || rsp_data.status == ST_SAT))
      else $error("undefined status code");

   a_depth_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_DEPTH) |->
         (rsp_data.dist_x == '0 && rsp_data.dist_y == '0))
      else $error("bad depth with nonzero result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind lens_distortion_projector lenp_chk u_chk (.*);
